[src/icm_pkg.sv]
// Shared types and constants for the itemset constraint matcher.
// Holds the transaction structs, command codes, controller states and the
// control/status structs that join the controller to the datapath. No dependencies.
package icm_pkg;

	localparam int ITEM_COUNT_DEF      = 4096;
	localparam int MAX_CONSTRAINTS_DEF = 8;
	localparam int COUNT_W             = 4;
	localparam int CFG_INDEX_W         = 2;

	// Command codes carried in the command field of an input transaction.
	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_ADD    = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_ITEMSET = 3'd3,
		CMD_SEARCH = 3'd4
	} cmd_e_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_POSITIVE_COUNT = 2'd0,
		REG_NEGATIVE_COUNT = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [11:0] item_id;
		logic        polarity;
		logic [2:0]  constraint_index;
		logic        element_valid;
		logic        element_last;
		logic        use_positive;
		logic        use_negative;
		logic        in_itemset;
		logic [15:0] prefix_support;
	} item_t;

	typedef struct packed {
		logic done_res;
		logic verdict;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;   // capture the transaction and read its store entry
		logic commit;   // apply the held transaction and load the result register
		logic sweep_en; // zero one store entry and advance the sweep pointer
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic result_full; // result register holds an undelivered transaction
		logic sweep_last;  // sweep pointer is on the final store entry
		logic clear_cmd;   // held transaction is a clear command
	} dp_status_t;

endpackage

[src/itemset_constraint_matcher.sv]
// Itemset constraint matcher: top level.
// Each transaction is accepted with its registered store read and then executed; the next
// is taken only after that execution, which waits while the result is held downstream.
// A result is loaded into the result register when its transaction executes.
// Reset and clear: the store is swept to zero, one entry a cycle, from the first entry to
// the last, during which no transaction is accepted; configuration writes are always taken.
module itemset_constraint_matcher #(
	parameter int ITEM_COUNT      = icm_pkg::ITEM_COUNT_DEF,
	parameter int MAX_CONSTRAINTS = icm_pkg::MAX_CONSTRAINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input transactions.
	input  logic                            item_valid,
	output logic                            item_stall,
	input  icm_pkg::item_t                  item,
	// Result transactions.
	output logic                            result_valid,
	input  logic                            result_stall,
	output icm_pkg::result_t                result,
	// Configuration writes.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [icm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [icm_pkg::COUNT_W-1:0]     cfg_data
);

	icm_pkg::ctrl_cmd_t  cmd;
	icm_pkg::dp_status_t status;
	logic                item_accept;

	// Configuration registers are plain flops, so a write is always taken.
	assign cfg_ready   = 1'b1;
	assign item_accept = item_valid && !item_stall;

	// The controller decides when a transaction is taken, when it is executed
	// and when the store is swept. Execution waits only if the result register
	// is still full and the downstream side is stalling; while it waits the
	// input is stalled, so a result held up downstream backs up the input.
	icm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd),
		.item_stall   (item_stall)
	);

	// The datapath holds the membership store (one bit per positive and per
	// negative constraint for every item), the hit registers of the query in
	// progress, the two count registers and the result register. Add is a
	// read-modify-write across the accept and execute cycles; a clear command
	// hands over to the sweep once its own result has been loaded.
	icm_datapath #(
		.ITEM_COUNT      (ITEM_COUNT),
		.MAX_CONSTRAINTS (MAX_CONSTRAINTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.result_stall (result_stall),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef SYNTHESIS
	// One transaction is in flight at a time: no acceptance on consecutive edges.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_accept |=> !item_accept)
		else $error("transaction accepted while the previous one was executing");

	// The sweep owns the store; no transaction may start or commit meanwhile.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_en |-> (!item_accept && !cmd.commit))
		else $error("store access overlapped the sweep");

	// A passing verdict is only ever given for a result that ends a query.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.done_res || !result.verdict))
		else $error("verdict set on a result that ends no query");
`endif

endmodule

[src/icm_ctrl.sv]
// Controller state machine for the itemset constraint matcher.
// Sequences the store sweep and the accept/execute steps of each transaction.
// Depends on icm_pkg.
module icm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  result_stall,
	input  icm_pkg::dp_status_t   status,
	output icm_pkg::ctrl_cmd_t    cmd,
	output logic                  item_stall
);

	icm_pkg::state_t state_q;
	icm_pkg::state_t state_d;
	logic            commit_ok;

	// The result register can take a new result when it is empty or draining.
	assign commit_ok = !status.result_full || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icm_pkg::ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icm_pkg::ST_SWEEP: begin
				if (status.sweep_last) begin
					state_d = icm_pkg::ST_IDLE;
				end
			end
			icm_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = icm_pkg::ST_EXEC;
				end
			end
			icm_pkg::ST_EXEC: begin
				if (commit_ok) begin
					state_d = status.clear_cmd ? icm_pkg::ST_SWEEP : icm_pkg::ST_IDLE;
				end
			end
			default: state_d = icm_pkg::ST_SWEEP;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			icm_pkg::ST_SWEEP: begin
				cmd.sweep_en = 1'b1;
			end
			icm_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				cmd.accept = item_valid;
			end
			icm_pkg::ST_EXEC: begin
				cmd.commit = commit_ok;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[src/icm_datapath.sv]
// Datapath for the itemset constraint matcher: membership store, sweep
// pointer, hit registers, configuration registers and result register.
// Depends on icm_pkg.
module icm_datapath #(
	parameter int ITEM_COUNT      = icm_pkg::ITEM_COUNT_DEF,
	parameter int MAX_CONSTRAINTS = icm_pkg::MAX_CONSTRAINTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  icm_pkg::item_t                  item,
	input  logic                            result_stall,
	input  logic                            cfg_write,
	input  logic [icm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [icm_pkg::COUNT_W-1:0]     cfg_data,
	input  icm_pkg::ctrl_cmd_t              cmd,
	output icm_pkg::dp_status_t             status,
	output logic                            result_valid,
	output icm_pkg::result_t                result
);

	localparam int IDX_W   = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
	localparam int ENTRY_W = 2 * MAX_CONSTRAINTS;

	logic [ENTRY_W-1:0]         mem [ITEM_COUNT];
	logic [ENTRY_W-1:0]         rd_q;
	icm_pkg::item_t             item_q;
	logic                       in_range_q;
	logic [IDX_W-1:0]           sweep_q;
	logic [icm_pkg::COUNT_W-1:0] pos_count_q;
	logic [icm_pkg::COUNT_W-1:0] neg_count_q;
	logic [MAX_CONSTRAINTS-1:0] pos_hits_q;
	logic [MAX_CONSTRAINTS-1:0] neg_hits_q;
	logic                       result_valid_q;
	icm_pkg::result_t           result_q;

	logic [IDX_W-1:0]           rd_addr;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_addr;
	logic [ENTRY_W-1:0]         wr_data;
	logic [ENTRY_W-1:0]         set_mask;
	logic [ENTRY_W-1:0]         entry;
	logic [MAX_CONSTRAINTS-1:0] pmask;
	logic [MAX_CONSTRAINTS-1:0] nmask;
	logic [MAX_CONSTRAINTS-1:0] pos_new;
	logic [MAX_CONSTRAINTS-1:0] neg_new;
	logic                       is_add;
	logic                       is_remove;
	logic                       is_clear;
	logic                       is_itemset;
	logic                       is_search;
	logic                       is_element;
	logic                       pos_take;
	logic                       ok_pos;
	logic                       ok_neg;
	logic                       ok;
	logic                       done;

	assign is_clear   = item_q.command == icm_pkg::CMD_CLEAR;
	assign is_add     = item_q.command == icm_pkg::CMD_ADD;
	assign is_remove  = item_q.command == icm_pkg::CMD_REMOVE;
	assign is_itemset = item_q.command == icm_pkg::CMD_ITEMSET;
	assign is_search  = item_q.command == icm_pkg::CMD_SEARCH;
	assign is_element = is_itemset || is_search;

	assign rd_addr = IDX_W'(item.item_id);

	// Bit to set for an add, and the active-constraint masks from the counts.
	// Counts above MAX_CONSTRAINTS simply enable every constraint.
	always_comb begin
		set_mask = '0;
		pmask    = '0;
		nmask    = '0;
		for (int i = 0; i < MAX_CONSTRAINTS; i++) begin
			set_mask[i]                 = !item_q.polarity &&
			                              (int'(item_q.constraint_index) == i);
			set_mask[MAX_CONSTRAINTS + i] = item_q.polarity &&
			                              (int'(item_q.constraint_index) == i);
			pmask[i] = int'(pos_count_q) > i;
			nmask[i] = int'(neg_count_q) > i;
		end
	end

	assign entry    = in_range_q ? rd_q : '0;
	assign pos_take = item_q.element_valid &&
	                  (is_itemset ||
	                   (is_search && (item_q.in_itemset || (item_q.prefix_support != '0))));
	assign pos_new  = pos_hits_q | (pos_take ? entry[MAX_CONSTRAINTS-1:0] : '0);
	assign neg_new  = neg_hits_q |
	                  ((item_q.element_valid && is_itemset) ?
	                   entry[ENTRY_W-1:MAX_CONSTRAINTS] : '0);
	assign ok_pos   = &(pos_new | ~pmask);
	assign ok_neg   = ~|(neg_new & nmask);
	assign ok       = is_itemset ?
	                  ((!item_q.use_positive || ok_pos) && (!item_q.use_negative || ok_neg)) :
	                  ok_pos;
	assign done     = is_element && item_q.element_last;

	// One write port shared by the sweep and by add/remove.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = IDX_W'(item_q.item_id);
		wr_data = '0;
		if (cmd.sweep_en) begin
			wr_en   = 1'b1;
			wr_addr = sweep_q;
		end else if (cmd.commit && in_range_q && is_add) begin
			wr_en   = 1'b1;
			wr_data = rd_q | set_mask;
		end else if (cmd.commit && in_range_q && is_remove) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.accept) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q     <= item;
			in_range_q <= int'(item.item_id) < ITEM_COUNT;
		end
		if (cmd.commit) begin
			result_q.done_res <= done;
			result_q.verdict  <= done && ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q        <= '0;
			pos_count_q    <= '0;
			neg_count_q    <= '0;
			pos_hits_q     <= '0;
			neg_hits_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep_en) begin
				sweep_q <= status.sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (cfg_write && (cfg_index == icm_pkg::REG_POSITIVE_COUNT)) begin
				pos_count_q <= cfg_data;
			end
			if (cfg_write && (cfg_index == icm_pkg::REG_NEGATIVE_COUNT)) begin
				neg_count_q <= cfg_data;
			end
			if (cmd.commit) begin
				if (is_clear || done) begin
					pos_hits_q <= '0;
					neg_hits_q <= '0;
				end else if (is_element) begin
					pos_hits_q <= pos_new;
					neg_hits_q <= neg_new;
				end
			end
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign status.result_full = result_valid_q;
	assign status.sweep_last  = sweep_q == IDX_W'(ITEM_COUNT - 1);
	assign status.clear_cmd   = is_clear;
	assign result_valid       = result_valid_q;
	assign result             = result_q;

endmodule

[sim/icm_checker.sv]
`timescale 1ns / 100ps
// Result checker for the itemset constraint matcher: watches all three channels,
// keeps its own membership store and verdict prediction, and compares every result.
// Depends on icm_pkg for the transaction structs, command codes and register indexes.
module icm_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_stall,
	input  icm_pkg::item_t                  item,
	input  logic                            result_valid,
	input  logic                            result_stall,
	input  icm_pkg::result_t                result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [icm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [icm_pkg::COUNT_W-1:0]     cfg_data,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int N_ITEMS = icm_pkg::ITEM_COUNT_DEF;
	localparam int N_CONS  = icm_pkg::MAX_CONSTRAINTS_DEF;

	// Low half of an entry holds the positive constraints, high half the negative ones.
	logic [2*N_CONS-1:0]         member_bits [N_ITEMS];
	logic [N_CONS-1:0]           pos_hits;
	logic [N_CONS-1:0]           neg_hits;
	logic [icm_pkg::COUNT_W-1:0] pos_count;
	logic [icm_pkg::COUNT_W-1:0] neg_count;
	icm_pkg::result_t            verdict_q [$];

	// Mask of the constraints in use; counts above the maximum saturate.
	function automatic logic [N_CONS-1:0] in_use(input logic [icm_pkg::COUNT_W-1:0] count);
		int n;
		logic [N_CONS:0] ones;
		n = (count > N_CONS) ? N_CONS : int'(count);
		ones = '0;
		ones[n] = 1'b1;
		ones = ones - 1'b1;
		return ones[N_CONS-1:0];
	endfunction

	// Applies one transaction to the shadow state and returns the result it should give.
	// Item IDs are 12 bits wide, so every ID addresses a real entry.
	function automatic icm_pkg::result_t apply_item(input icm_pkg::item_t t);
		logic [2*N_CONS-1:0] entry;
		logic [N_CONS-1:0]   pos_need;
		logic [N_CONS-1:0]   neg_need;
		logic                pos_ok;
		logic                neg_ok;
		icm_pkg::result_t    r;
		r = '0;
		pos_need = in_use(pos_count);
		neg_need = in_use(neg_count);
		case (t.command)
			icm_pkg::CMD_CLEAR: begin
				foreach (member_bits[i]) member_bits[i] = '0;
				pos_hits = '0;
				neg_hits = '0;
			end
			icm_pkg::CMD_ADD: member_bits[t.item_id][{t.polarity, t.constraint_index}] = 1'b1;
			icm_pkg::CMD_REMOVE: member_bits[t.item_id] = '0;
			icm_pkg::CMD_ITEMSET, icm_pkg::CMD_SEARCH: begin
				entry = member_bits[t.item_id];
				if (t.element_valid) begin
					if (t.command == icm_pkg::CMD_ITEMSET) begin
						pos_hits |= entry[N_CONS-1:0];
						neg_hits |= entry[2*N_CONS-1:N_CONS];
					end else if (t.in_itemset || t.prefix_support != '0) begin
						pos_hits |= entry[N_CONS-1:0];
					end
				end
				if (t.element_last) begin
					pos_ok = (pos_hits & pos_need) == pos_need;
					neg_ok = (neg_hits & neg_need) == '0;
					r.done_res = 1'b1;
					if (t.command == icm_pkg::CMD_ITEMSET) begin
						r.verdict = (!t.use_positive || pos_ok) && (!t.use_negative || neg_ok);
					end else begin
						r.verdict = pos_ok;
					end
					pos_hits = '0;
					neg_hits = '0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int               errs;
		icm_pkg::result_t want;
		errs = 0;
		if (!arst_n) begin
			foreach (member_bits[i]) member_bits[i] = '0;
			pos_hits = '0;
			neg_hits = '0;
			pos_count = '0;
			neg_count = '0;
			verdict_q.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					icm_pkg::REG_POSITIVE_COUNT: pos_count = cfg_data;
					icm_pkg::REG_NEGATIVE_COUNT: neg_count = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					$error("result transaction arrived with none expected");
					errs++;
				end else begin
					want = verdict_q.pop_front();
					if (result.done_res !== want.done_res) begin
						$error("done_res: expected %0b, actual %0b", want.done_res,
							result.done_res);
						errs++;
					end
					if (result.verdict !== want.verdict) begin
						$error("verdict: expected %0b, actual %0b", want.verdict,
							result.verdict);
						errs++;
					end
				end
			end
			if (item_valid && !item_stall) verdict_q.push_back(apply_item(item));
			outstanding <= verdict_q.size();
			mismatches <= mismatches + errs;
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Top level of the itemset constraint matcher testbench: clock, reset, stimulus,
// flow control and the final verdict. Depends on icm_pkg and icm_checker.
module testbench;

	localparam int CYCLE_LIMIT  = 600_000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int PHASES       = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_WAIT  = 4;

	localparam logic POL_POSITIVE = 1'b0;
	localparam logic POL_NEGATIVE = 1'b1;

	// Register indexes and commands that the block has no use for.
	localparam logic [icm_pkg::CFG_INDEX_W-1:0] REG_SPARE_A      = 2'd2;
	localparam logic [icm_pkg::CFG_INDEX_W-1:0] REG_SPARE_B      = 2'd3;
	localparam logic [2:0]                      CMD_FIRST_UNUSED = 3'd5;
	localparam logic [2:0]                      CMD_LAST_UNUSED  = 3'd7;

	logic                            clk;
	logic                            arst_n;
	logic                            item_valid;
	logic                            item_stall;
	icm_pkg::item_t                  item;
	logic                            result_valid;
	logic                            result_stall;
	icm_pkg::result_t                result;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [icm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [icm_pkg::COUNT_W-1:0]     cfg_data;
	int                              mismatches;
	int                              outstanding;
	int                              cycle_count;

	// Flow-control knobs shared between the stimulus and the result receiver.
	bit gaps_on;
	bit calm;
	bit hold_req;

	itemset_constraint_matcher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	icm_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Result receiver. It normally stalls in short random bursts, holds off for a long
	// stretch when the stimulus asks for it (so that the block backs up and stalls its
	// input), and stops stalling altogether once the run has gone calm.
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Builds one input transaction field by field.
	function automatic icm_pkg::item_t make_item(input logic [2:0] cmd,
			input logic [11:0] id, input logic pol, input logic [2:0] cidx,
			input logic ev, input logic el, input logic up, input logic un,
			input logic ins, input logic [15:0] ps);
		icm_pkg::item_t t;
		t.command          = cmd;
		t.item_id          = id;
		t.polarity         = pol;
		t.constraint_index = cidx;
		t.element_valid    = ev;
		t.element_last     = el;
		t.use_positive     = up;
		t.use_negative     = un;
		t.in_itemset       = ins;
		t.prefix_support   = ps;
		return t;
	endfunction

	// Most IDs come from a small pool so that queries actually meet stored members;
	// the extremes and the odd ID from the full range are mixed in.
	function automatic logic [11:0] pick_id();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 12'($urandom);
			default: return 12'($urandom_range(0, 15));
		endcase
	endfunction

	// Random transaction: the fields a command ignores are left as noise, while the
	// command mix favours membership adds and query elements so that queries of a few
	// elements, some of them passing, make up most of the traffic.
	function automatic icm_pkg::item_t random_item();
		icm_pkg::item_t t;
		logic [63:0]    noise;
		int             pick;
		noise = {$urandom, $urandom};
		t = noise[$bits(icm_pkg::item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 1)       t.command = icm_pkg::CMD_CLEAR;
		else if (pick < 21) t.command = icm_pkg::CMD_ADD;
		else if (pick < 25) t.command = icm_pkg::CMD_REMOVE;
		else if (pick < 28) t.command = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
		else if (pick < 68) t.command = icm_pkg::CMD_ITEMSET;
		else                t.command = icm_pkg::CMD_SEARCH;
		t.item_id = pick_id();
		t.element_valid = ($urandom_range(0, 9) != 0);
		t.element_last = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: t.prefix_support = '0;
			4: t.prefix_support = '1;
			default: ;
		endcase
		return t;
	endfunction

	// Offers one transaction and waits until it is taken. The valid is only lowered
	// when a random gap follows, so back-to-back transactions keep it high.
	task automatic put_item(input icm_pkg::item_t t);
		int gap;
		item <= t;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		gap = 0;
		if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every expected result has come back, then lets
	// the pipeline empty.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_register(input logic [icm_pkg::CFG_INDEX_W-1:0] idx,
			input logic [icm_pkg::COUNT_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [icm_pkg::COUNT_W-1:0] pos_plan [PHASES];
		logic [icm_pkg::COUNT_W-1:0] neg_plan [PHASES];
		logic [icm_pkg::COUNT_W-1:0] pos_n;
		logic [icm_pkg::COUNT_W-1:0] neg_n;
		pos_plan = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd1, 4'd8, 4'd0, 4'd5};
		neg_plan = '{4'd0, 4'd8, 4'd15, 4'd2, 4'd7, 4'd0, 4'd8, 4'd4};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gaps_on = 1'b1;
		calm = 1'b0;
		hold_req = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two positive constraints and one negative one for the directed part. The
		// spare indexes must leave both counts alone.
		write_register(icm_pkg::REG_POSITIVE_COUNT, 4'd2);
		write_register(icm_pkg::REG_NEGATIVE_COUNT, 4'd1);
		write_register(REG_SPARE_A, 4'd15);
		write_register(REG_SPARE_B, 4'd0);

		// Memberships, including some on constraints that are not in use.
		put_item(make_item(icm_pkg::CMD_ADD, 12'd0, POL_POSITIVE, 3'd0, 0, 0, 0, 0, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_ADD, 12'd4095, POL_POSITIVE, 3'd1, 0, 0, 0, 0, 0,
			16'd0));
		put_item(make_item(icm_pkg::CMD_ADD, 12'd100, POL_NEGATIVE, 3'd0, 0, 0, 0, 0, 0,
			16'd0));
		put_item(make_item(icm_pkg::CMD_ADD, 12'd200, POL_POSITIVE, 3'd7, 0, 0, 0, 0, 0,
			16'd0));
		put_item(make_item(icm_pkg::CMD_ADD, 12'd300, POL_NEGATIVE, 3'd7, 0, 0, 0, 0, 0,
			16'd0));
		// Full match covering both positives and no negative: passes.
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd0, 0, 0, 1, 0, 1, 1, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd4095, 0, 0, 1, 1, 1, 1, 0, 16'd0));
		// Second positive missing and a negative hit: fails.
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd0, 0, 0, 1, 0, 1, 1, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd100, 0, 0, 1, 1, 1, 1, 0, 16'd0));
		// Both classes skipped, so nothing can fail.
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd100, 0, 0, 1, 1, 0, 0, 0, 16'd0));
		// Empty query on fresh hits.
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd0, 0, 0, 0, 1, 1, 0, 0, 16'd0));
		// Search space: an element outside the itemset with no support does not count.
		put_item(make_item(icm_pkg::CMD_SEARCH, 12'd4095, 0, 0, 1, 0, 0, 0, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_SEARCH, 12'd0, 0, 0, 1, 1, 0, 0, 0, 16'hFFFF));
		// Mixed query closed by an empty search-space element: positives only.
		put_item(make_item(icm_pkg::CMD_SEARCH, 12'd4095, 0, 0, 1, 0, 0, 0, 1, 16'd0));
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd0, 0, 0, 1, 0, 1, 0, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_SEARCH, 12'd100, 0, 0, 0, 1, 0, 0, 0, 16'd0));
		// Removal drops every membership of the item.
		put_item(make_item(icm_pkg::CMD_REMOVE, 12'd4095, 0, 0, 0, 0, 0, 0, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd0, 0, 0, 1, 0, 1, 1, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd4095, 0, 0, 1, 1, 1, 1, 0, 16'd0));
		// An unknown command, even one flagged as last, gives no verdict.
		put_item(make_item(CMD_LAST_UNUSED, 12'hFFF, 1, 3'd7, 1, 1, 1, 1, 1, 16'hFFFF));
		// Clear empties the store: nothing satisfies the positives afterwards.
		put_item(make_item(icm_pkg::CMD_CLEAR, 12'd0, 0, 0, 0, 0, 0, 0, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd0, 0, 0, 1, 1, 1, 0, 0, 16'd0));
		put_item(make_item(icm_pkg::CMD_ITEMSET, 12'd200, 0, 0, 1, 1, 1, 1, 0, 16'd0));
		settle();

		// Random phases, each with its own pair of counts. The second phase starts
		// with the receiver holding off while transactions keep coming, and the last
		// one runs without any idling on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) begin
				pos_n = 4'($urandom_range(0, 15));
				neg_n = 4'($urandom_range(0, 15));
				calm = 1'b1;
				gaps_on = 1'b0;
			end else begin
				pos_n = pos_plan[ph];
				neg_n = neg_plan[ph];
			end
			write_register(icm_pkg::REG_POSITIVE_COUNT, pos_n);
			write_register(icm_pkg::REG_NEGATIVE_COUNT, neg_n);
			if (ph == 1) begin
				hold_req = 1'b1;
				gaps_on = 1'b0;
			end
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
				if (ph == 1 && n == 60) gaps_on = 1'b1;
				put_item(random_item());
			end
			// Pause the sender until every result of the phase is back.
			settle();
		end

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[files.f]
src/icm_pkg.sv
src/icm_ctrl.sv
src/icm_datapath.sv
src/itemset_constraint_matcher.sv
sim/icm_checker.sv
sim/testbench.sv
